/* src/sas_pkg.sv */
// Package for the stripe access splitter: widths, configuration defaults,
// register indexes and the command/status structs between controller and datapath.
// Depends on nothing.
package sas_pkg;

    localparam int KIND_W      = 3;
    localparam int OFFSET_BITS = 40;
    localparam int LEN_W       = 13;
    localparam int DEV_W       = 3;
    localparam int NDEV_W      = 4;
    localparam int STRIP_W     = 33;
    localparam int STRIPE_W    = 36;
    localparam int CNT_W       = $clog2(OFFSET_BITS);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 33;

    localparam int MAX_DEVICES = 8;
    localparam int MIN_STRIP   = 128;
    localparam int MAX_ACCESS  = 4096;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 72;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_DEVICES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIP_SIZE  = 2'd1;

    localparam logic [NDEV_W-1:0]  NDEV_RESET  = 4'd1;
    localparam logic [STRIP_W-1:0] STRIP_RESET = 33'd4096;

    typedef struct packed {
        logic load;
        logic div_step;
        logic dev_step;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic single;
        logic dev_done;
        logic seg_last;
        logic out_free;
    } ctrl_status_t;

endpackage

/* src/sas_ctrl.sv */
// Controller of the stripe access splitter: sequences load, division,
// device extraction and segment output. Depends on sas_pkg.
module sas_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  sas_pkg::ctrl_status_t  status,
    output sas_pkg::ctrl_cmd_t     cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DEV  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    localparam logic [sas_pkg::CNT_W-1:0] CNT_LAST =
        sas_pkg::CNT_W'(sas_pkg::OFFSET_BITS - 1);

    logic [1:0]                state_reg, state_next;
    logic [sas_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = status.single ? ST_EMIT : ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    state_next = ST_DEV;
                end
            end
            ST_DEV: begin
                if (status.dev_done) begin
                    state_next = ST_EMIT;
                end else begin
                    cmd.dev_step = 1'b1;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.seg_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

/* src/sas_datapath.sv */
// Datapath of the stripe access splitter: configuration registers, bit-serial
// division by the stripe size, device extraction and segment output register.
// Depends on sas_pkg.
module sas_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    input  logic [sas_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sas_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic [sas_pkg::KIND_W-1:0]           in_cmd,
    input  logic [sas_pkg::OFFSET_BITS-1:0]      in_start_offset,
    input  logic [sas_pkg::LEN_W-1:0]            in_access_length,
    input  sas_pkg::ctrl_cmd_t                   cmd,
    output sas_pkg::ctrl_status_t                status,
    input  logic                                 out_ready,
    output logic                                 out_valid,
    output logic [sas_pkg::KIND_W-1:0]           out_kind,
    output logic [sas_pkg::DEV_W-1:0]            out_device_index,
    output logic [sas_pkg::OFFSET_BITS-1:0]      out_device_offset,
    output logic [sas_pkg::LEN_W-1:0]            out_segment_length,
    output logic [sas_pkg::LEN_W-1:0]            out_buffer_offset,
    output logic                                 out_last_segment
);

    localparam int OB = sas_pkg::OFFSET_BITS;
    localparam int SW = sas_pkg::STRIP_W;
    localparam int PW = sas_pkg::STRIPE_W;
    localparam int LW = sas_pkg::LEN_W;

    logic [sas_pkg::NDEV_W-1:0] ndev_cfg_reg;
    logic [SW-1:0]              strip_cfg_reg;

    logic [sas_pkg::NDEV_W-1:0] ndev_eff;
    logic [SW-1:0]              strip_eff;
    logic [LW-1:0]              len_eff;

    logic [sas_pkg::KIND_W-1:0] kind_reg;
    logic [OB-1:0]              num_reg;
    logic [PW-1:0]              rem_reg;
    logic [OB-1:0]              base_reg;
    logic [sas_pkg::DEV_W-1:0]  dev_reg;
    logic [LW-1:0]              pos_reg;
    logic [LW-1:0]              len_reg;
    logic [SW-1:0]              strip_reg;
    logic [PW-1:0]              stripe_reg;
    logic [sas_pkg::NDEV_W-1:0] ndev_reg;
    logic                       single_reg;
    logic                       out_valid_reg;

    logic [PW:0]                div_trial;
    logic                       div_ge;
    logic [PW:0]                div_diff;
    logic [SW:0]                room;
    logic [LW-1:0]              rem_len;
    logic [LW-1:0]              seg;
    logic [sas_pkg::NDEV_W-1:0] dev_inc;
    logic                       dev_wrap;

    always_comb begin
        if (ndev_cfg_reg == '0) begin
            ndev_eff = sas_pkg::NDEV_W'(1);
        end else if (ndev_cfg_reg > sas_pkg::NDEV_W'(sas_pkg::MAX_DEVICES)) begin
            ndev_eff = sas_pkg::NDEV_W'(sas_pkg::MAX_DEVICES);
        end else begin
            ndev_eff = ndev_cfg_reg;
        end
        strip_eff = (strip_cfg_reg < SW'(sas_pkg::MIN_STRIP)) ?
                    SW'(sas_pkg::MIN_STRIP) : strip_cfg_reg;
        len_eff   = (in_access_length > LW'(sas_pkg::MAX_ACCESS)) ?
                    LW'(sas_pkg::MAX_ACCESS) : in_access_length;
    end

    always_comb begin
        div_trial = {rem_reg, num_reg[OB-1]};
        div_ge    = div_trial >= {1'b0, stripe_reg};
        div_diff  = div_trial - {1'b0, stripe_reg};
        room      = {1'b0, strip_reg} - (SW+1)'(rem_reg);
        rem_len   = len_reg - pos_reg;
        if (single_reg || (room >= (SW+1)'(rem_len))) begin
            seg = rem_len;
        end else begin
            seg = room[LW-1:0];
        end
        dev_inc  = {1'b0, dev_reg} + 1'b1;
        dev_wrap = dev_inc == ndev_reg;
    end

    assign status.single   = ndev_eff == sas_pkg::NDEV_W'(1);
    assign status.dev_done = rem_reg < PW'(strip_reg);
    assign status.seg_last = seg == rem_len;
    assign status.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ndev_cfg_reg  <= sas_pkg::NDEV_RESET;
            strip_cfg_reg <= sas_pkg::STRIP_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == sas_pkg::CFG_NUM_DEVICES) begin
                ndev_cfg_reg <= cfg_data[sas_pkg::NDEV_W-1:0];
            end else if (cfg_index == sas_pkg::CFG_STRIP_SIZE) begin
                strip_cfg_reg <= cfg_data[SW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg   <= in_cmd;
            num_reg    <= in_start_offset;
            rem_reg    <= '0;
            base_reg   <= status.single ? in_start_offset : '0;
            dev_reg    <= '0;
            pos_reg    <= '0;
            len_reg    <= len_eff;
            strip_reg  <= strip_eff;
            stripe_reg <= PW'(strip_eff) * PW'(ndev_eff);
            ndev_reg   <= ndev_eff;
            single_reg <= status.single;
        end else if (cmd.div_step) begin
            num_reg  <= {num_reg[OB-2:0], 1'b0};
            rem_reg  <= div_ge ? div_diff[PW-1:0] : div_trial[PW-1:0];
            base_reg <= {base_reg[OB-2:0], 1'b0} + (div_ge ? OB'(strip_reg) : '0);
        end else if (cmd.dev_step) begin
            rem_reg <= rem_reg - PW'(strip_reg);
            dev_reg <= dev_reg + 1'b1;
        end else if (cmd.emit) begin
            pos_reg <= pos_reg + seg;
            rem_reg <= '0;
            if (!single_reg) begin
                dev_reg <= dev_wrap ? '0 : dev_inc[sas_pkg::DEV_W-1:0];
                if (dev_wrap) begin
                    base_reg <= base_reg + OB'(strip_reg);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_kind           <= kind_reg;
            out_device_index   <= dev_reg;
            out_device_offset  <= base_reg + OB'(rem_reg);
            out_segment_length <= seg;
            out_buffer_offset  <= pos_reg;
            out_last_segment   <= status.seg_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("Segment issued while the output register was occupied.");

    a_dev_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && !single_reg) |-> ({1'b0, dev_reg} < ndev_reg))
        else $error("Device index is not below the device count.");

    a_seg_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && !status.seg_last) |-> (seg != '0))
        else $error("Empty segment that is not the last one.");

    a_in_strip: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (rem_reg < PW'(strip_reg)))
        else $error("Offset within the strip is not below the strip size.");

endmodule

/* src/stripe_access_splitter.sv */
// Stripe access splitter top level: stream ports, controller and datapath.
// Depends on sas_pkg, sas_ctrl and sas_datapath.
//
// Usage: one transfer on the s_axis channel carries a logical access (start
// offset, length, kind) into an area interleaved across several devices in
// strips. The block returns one m_axis transfer per strip that the access
// touches, in ascending order, with m_axis_tlast on the final one. A
// zero-length access returns one empty segment.
// The cfg channel writes the device count (index 0) and strip size (index 1);
// it is always ready; the user must write it only while the block is idle,
// as the block itself does not enforce this. With one device the access skips
// division and device extraction and leaves as a single segment. Otherwise the
// start offset is divided by the stripe size one quotient bit per cycle, then
// the device is found by up to 7 strip subtractions, and segments follow at one
// per cycle while m_axis_tready does not stall the output register.
// s_axis_tready rises again in the cycle after the last segment enters the
// output register, so a new access is taken only after the last one is split.
// A stalled m_axis_tready holds the output register and pauses segmenting.
// Reset sets 1 device and 4096-byte strips and drops any access in flight.
module stripe_access_splitter (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // Bits from low: start_offset (40), access_length (13), zero fill.
    input  logic [sas_pkg::S_TDATA_W-1:0]        s_axis_tdata,
    // Bits from low: cmd (3).
    input  logic [sas_pkg::KIND_W-1:0]           s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // Bits from low: device_index (3), device_offset (40),
    // segment_length (13), buffer_offset (13), zero fill.
    output logic [sas_pkg::M_TDATA_W-1:0]        m_axis_tdata,
    // Bits from low: kind (3).
    output logic [sas_pkg::KIND_W-1:0]           m_axis_tuser,
    output logic                                 m_axis_tlast,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [sas_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sas_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int OB = sas_pkg::OFFSET_BITS;
    localparam int LW = sas_pkg::LEN_W;
    localparam int DW = sas_pkg::DEV_W;
    localparam int FILL_W = sas_pkg::M_TDATA_W - DW - OB - 2 * LW;

    sas_pkg::ctrl_cmd_t    cmd;
    sas_pkg::ctrl_status_t status;

    logic [DW-1:0] dev_index;
    logic [OB-1:0] dev_offset;
    logic [LW-1:0] seg_length;
    logic [LW-1:0] buf_offset;

    assign cfg_ready = 1'b1;

    sas_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sas_datapath u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_cmd             (s_axis_tuser),
        .in_start_offset    (s_axis_tdata[OB-1:0]),
        .in_access_length   (s_axis_tdata[OB+LW-1:OB]),
        .cmd                (cmd),
        .status             (status),
        .out_ready          (m_axis_tready),
        .out_valid          (m_axis_tvalid),
        .out_kind           (m_axis_tuser),
        .out_device_index   (dev_index),
        .out_device_offset  (dev_offset),
        .out_segment_length (seg_length),
        .out_buffer_offset  (buf_offset),
        .out_last_segment   (m_axis_tlast)
    );

    assign m_axis_tdata = {{FILL_W{1'b0}}, buf_offset, seg_length, dev_offset, dev_index};

endmodule
